### rtl/sjc_pkg.sv
`timescale 1ns / 1ps
package sjc_pkg;

	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 24;
	localparam int ZONE_W    = 17;
	localparam int AXIS_W    = 18;
	localparam int TICK_W    = 20;
	localparam int VAL_W     = 32;
	localparam int CH_W      = 3;
	localparam int MUL_BW    = 25;
	localparam int MEM_DEPTH = 16;
	localparam int MEM_AW    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_ARM_SCALE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ARM_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_LIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ANG   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_GAIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LIN_ACCEL  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_ANG_ACCEL  = 3'd7;

	localparam logic MODE_ARM  = 1'b0;
	localparam logic MODE_BASE = 1'b1;

	typedef logic [CFG_W-1:0] cfg_word_t;

endpackage

### rtl/sjc_ram.sv
`timescale 1ns / 1ps
module sjc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/sjc_mul.sv
`timescale 1ns / 1ps
module sjc_mul
	import sjc_pkg::*;
#(
	parameter int AW = 33
) (
	input  logic                           clk,
	input  logic signed [AW-1:0]           a,
	input  logic signed [MUL_BW-1:0]       b,
	output logic signed [AW+MUL_BW-1:0]    p
);

	logic signed [AW+MUL_BW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

### rtl/six_axis_joystick_conditioner.sv
`timescale 1ns / 1ps
// Channel | Direction | Signals
// in      | input     | in_valid, in_stall, axis_0..axis_5, button_pressed, elapsed_ticks
// out     | output    | out_valid, out_stall, mode_flag, channel, level_value, rate_value,
//         |           | last_of_run
// cfg     | input     | cfg_we, cfg_index, cfg_data
// One sample runs through seven sequencer steps per result on one shared multiplier:
// six results for an arm sample, four results for a base sample.
// Positions and velocities live in one 16 x 32 RAM with a valid bit per entry; reset
// clears the valid bits, mode and holdoff at once, so no clearing pass is needed.
// A stall on out holds the sequencer at its emit step; in is stalled while a sample runs.
module six_axis_joystick_conditioner
	import sjc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [AXIS_W-1:0]    axis_0,
	input  logic signed [AXIS_W-1:0]    axis_1,
	input  logic signed [AXIS_W-1:0]    axis_2,
	input  logic signed [AXIS_W-1:0]    axis_3,
	input  logic signed [AXIS_W-1:0]    axis_4,
	input  logic signed [AXIS_W-1:0]    axis_5,
	input  logic                        button_pressed,
	input  logic [TICK_W-1:0]           elapsed_ticks,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        mode_flag,
	output logic [CH_W-1:0]             channel,
	output logic signed [VAL_W-1:0]     level_value,
	output logic signed [VAL_W-1:0]     rate_value,
	output logic                        last_of_run
);

	localparam int SW   = 45 - FRAC_BITS;
	localparam int AW   = (SW > VAL_W + 1) ? SW : VAL_W + 1;
	localparam int PW   = AW + MUL_BW;
	localparam int EW   = PW + 1;
	localparam int HOLD_W = FRAC_BITS + 5;
	localparam int HSUM_W = ((HOLD_W > TICK_W) ? HOLD_W : TICK_W) + 1;
	localparam longint ONE_Q = longint'(1) << FRAC_BITS;
	localparam logic [HSUM_W-1:0] HOLD_MAX  = HSUM_W'((longint'(1) << HOLD_W) - 1);
	localparam logic [HSUM_W-1:0] HALF_SEC  = HSUM_W'(longint'(1) << (FRAC_BITS - 1));
	localparam logic signed [PW-1:0] RND_HALF = PW'(longint'(1) << (FRAC_BITS - 1));
	localparam logic [ZONE_W-1:0] VERT_ZONE = ZONE_W'((ONE_Q + 5) / 10);
	localparam logic [CFG_W-1:0]  VERT_GAIN = CFG_W'((ONE_Q + 3) / 6);
	localparam logic signed [EW-1:0] MAX32 = EW'(64'sh7FFF_FFFF);
	localparam logic signed [EW-1:0] MIN32 = -EW'(64'sh8000_0000);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL1 = 3'd1;
	localparam logic [2:0] ST_SCL  = 3'd2;
	localparam logic [2:0] ST_DZ   = 3'd3;
	localparam logic [2:0] ST_TGT  = 3'd4;
	localparam logic [2:0] ST_MUL3 = 3'd5;
	localparam logic [2:0] ST_LVL  = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	function automatic logic signed [PW-1:0] rescale(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] t;
		t = v + RND_HALF - PW'(v[PW-1]);
		return t >>> FRAC_BITS;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [EW-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > MAX32) begin
			r = MAX32[VAL_W-1:0];
		end else if (v < MIN32) begin
			r = MIN32[VAL_W-1:0];
		end else begin
			r = v[VAL_W-1:0];
		end
		return r;
	endfunction

	cfg_word_t                    cfg_q [NUM_CFG];
	logic [2:0]                   state_q;
	logic                         mode_q;
	logic [HOLD_W-1:0]            hold_q;
	logic [CH_W-1:0]              ch_q;
	logic signed [AXIS_W-1:0]     ax_q [6];
	logic [TICK_W-1:0]            dt_q;
	logic signed [SW-1:0]         t_q;
	logic                         dz_q;
	logic signed [VAL_W-1:0]      r_q;
	logic signed [VAL_W-1:0]      cur_q;
	logic signed [VAL_W-1:0]      lvl_q;
	logic [MEM_DEPTH-1:0]         vld_q;
	logic                         ovalid_q;
	logic                         omode_q;
	logic [CH_W-1:0]              och_q;
	logic signed [VAL_W-1:0]      olvl_q;
	logic signed [VAL_W-1:0]      orate_q;
	logic                         olast_q;

	logic                         in_xfer;
	logic                         out_free;
	logic [HSUM_W-1:0]            hsum;
	logic [HSUM_W-1:0]            hnext;
	logic                         toggle;
	logic                         is_base;
	logic                         vert;
	logic                         last_ch;
	logic [2:0]                   src;
	logic                         neg;
	logic [MEM_AW-1:0]            addr;
	logic [VAL_W-1:0]             rdata;
	logic signed [AW-1:0]         mul_a;
	logic signed [MUL_BW-1:0]     mul_b;
	logic signed [PW-1:0]         prod;
	logic signed [PW-1:0]         rs;
	logic signed [SW-1:0]         zone;
	logic signed [SW-1:0]         dval;
	logic                         dzone;
	logic signed [VAL_W-1:0]      cval;
	logic signed [VAL_W-1:0]      rval;
	logic signed [EW-1:0]         fv;
	logic signed [EW-1:0]         ftg;
	logic signed [EW-1:0]         fnv;
	logic signed [VAL_W-1:0]      lvl_d;
	logic                         mem_we;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !ovalid_q || !out_stall;
	assign is_base  = (mode_q == MODE_BASE);
	assign vert     = is_base && (ch_q == CH_W'(2));
	assign last_ch  = is_base ? (ch_q == CH_W'(3)) : (ch_q == CH_W'(5));
	assign mem_we   = (state_q == ST_EMIT) && out_free && !vert;

	assign hsum   = HSUM_W'(hold_q) + HSUM_W'(elapsed_ticks);
	assign hnext  = (hsum > HOLD_MAX) ? HOLD_MAX : hsum;
	assign toggle = button_pressed && (hnext >= HALF_SEC);

	always_comb begin
		src = 3'd0;
		neg = 1'b0;
		if (is_base) begin
			case (ch_q)
				3'd0:    src = 3'd0;
				3'd1:    src = 3'd1;
				3'd2:    src = 3'd2;
				default: src = 3'd5;
			endcase
		end else begin
			case (ch_q)
				3'd0:    begin src = 3'd2; neg = 1'b1; end
				3'd1:    begin src = 3'd1; neg = 1'b0; end
				3'd2:    begin src = 3'd0; neg = 1'b1; end
				3'd3:    begin src = 3'd3; neg = 1'b1; end
				3'd4:    begin src = 3'd5; neg = 1'b1; end
				default: begin src = 3'd4; neg = 1'b1; end
			endcase
		end
	end

	always_comb begin
		if (is_base) begin
			addr = (ch_q == CH_W'(3)) ? MEM_AW'(10) : MEM_AW'(8) + MEM_AW'(ch_q);
		end else begin
			addr = MEM_AW'(ch_q);
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MUL1: begin
				mul_a = AW'(ax_q[src]);
				if (!is_base) begin
					mul_b = MUL_BW'(cfg_q[CFG_ARM_SCALE]);
				end else if (ch_q == CH_W'(3)) begin
					mul_b = MUL_BW'(cfg_q[CFG_BASE_ANG]);
				end else begin
					mul_b = MUL_BW'(cfg_q[CFG_BASE_LIN]);
				end
			end
			ST_DZ: begin
				mul_a = AW'(dval);
				if (!is_base) begin
					mul_b = MUL_BW'(cfg_q[CFG_ARM_GAIN]);
				end else if (vert) begin
					mul_b = MUL_BW'(VERT_GAIN);
				end else begin
					mul_b = MUL_BW'(cfg_q[CFG_BASE_GAIN]);
				end
			end
			ST_MUL3: begin
				if (!is_base) begin
					mul_a = AW'(r_q);
					mul_b = MUL_BW'(dt_q);
				end else begin
					mul_a = AW'(dt_q);
					mul_b = (ch_q == CH_W'(3)) ? MUL_BW'(cfg_q[CFG_ANG_ACCEL])
					                           : MUL_BW'(cfg_q[CFG_LIN_ACCEL]);
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	sjc_mul #(.AW(AW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign rs = rescale(prod);

	always_comb begin
		zone  = vert ? SW'(VERT_ZONE) : SW'(cfg_q[CFG_DEAD_ZONE][ZONE_W-1:0]);
		dzone = 1'b0;
		if (t_q > zone) begin
			dval = t_q - zone;
		end else if (t_q < -zone) begin
			dval = t_q + zone;
		end else begin
			dval  = '0;
			dzone = 1'b1;
		end
	end

	always_comb begin
		cval = dz_q ? '0 : sat32(EW'(rs));
		if (!is_base && neg) begin
			rval = sat32(-EW'(cval));
		end else begin
			rval = cval;
		end
	end

	always_comb begin
		fv  = EW'(cur_q);
		ftg = EW'(r_q);
		fnv = fv;
		if (ftg > fv) begin
			fnv = fv + EW'(rs);
			if (fnv >= ftg) begin
				fnv = ftg;
			end
		end else if (ftg < fv) begin
			fnv = fv - EW'(rs);
			if (fnv <= ftg) begin
				fnv = ftg;
			end
		end
		if (!is_base) begin
			lvl_d = sat32(EW'(cur_q) + EW'(rs));
		end else if (vert) begin
			lvl_d = r_q;
		end else begin
			lvl_d = fnv[VAL_W-1:0];
		end
	end

	sjc_ram #(.WIDTH(VAL_W), .DEPTH(MEM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr),
		.wdata (lvl_q),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[CFG_ARM_SCALE] <= CFG_W'(6554);
			cfg_q[CFG_DEAD_ZONE] <= CFG_W'(918);
			cfg_q[CFG_ARM_GAIN]  <= CFG_W'(85924);
			cfg_q[CFG_BASE_LIN]  <= CFG_W'(360448);
			cfg_q[CFG_BASE_ANG]  <= CFG_W'(458752);
			cfg_q[CFG_BASE_GAIN] <= CFG_W'(3922);
			cfg_q[CFG_LIN_ACCEL] <= CFG_W'(1311);
			cfg_q[CFG_ANG_ACCEL] <= CFG_W'(6554);
		end else if (cfg_we) begin
			if (cfg_index == CFG_DEAD_ZONE) begin
				cfg_q[cfg_index] <= CFG_W'(cfg_data[ZONE_W-1:0]);
			end else begin
				cfg_q[cfg_index] <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_ARM;
			hold_q   <= '0;
			ch_q     <= '0;
			vld_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall && state_q != ST_EMIT) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						ch_q    <= '0;
						state_q <= ST_MUL1;
						if (toggle) begin
							mode_q <= !mode_q;
							hold_q <= '0;
						end else begin
							hold_q <= hnext[HOLD_W-1:0];
						end
					end
				end
				ST_MUL1: state_q <= ST_SCL;
				ST_SCL:  state_q <= ST_DZ;
				ST_DZ:   state_q <= ST_TGT;
				ST_TGT:  state_q <= ST_MUL3;
				ST_MUL3: state_q <= ST_LVL;
				ST_LVL:  state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						if (mem_we) begin
							vld_q[addr] <= 1'b1;
						end
						if (last_ch) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= ST_MUL1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ax_q[0] <= axis_0;
			ax_q[1] <= axis_1;
			ax_q[2] <= axis_2;
			ax_q[3] <= axis_3;
			ax_q[4] <= axis_4;
			ax_q[5] <= axis_5;
			dt_q    <= elapsed_ticks;
		end
		if (state_q == ST_SCL) begin
			cur_q <= vld_q[addr] ? rdata : '0;
			if (vert) begin
				t_q <= SW'(ax_q[2]);
			end else if (!is_base) begin
				t_q <= SW'(-rs);
			end else begin
				t_q <= SW'(rs);
			end
		end
		if (state_q == ST_DZ) begin
			dz_q <= dzone;
		end
		if (state_q == ST_TGT) begin
			r_q <= rval;
		end
		if (state_q == ST_LVL) begin
			lvl_q <= lvl_d;
		end
		if (state_q == ST_EMIT && out_free) begin
			omode_q <= mode_q;
			och_q   <= ch_q;
			olvl_q  <= lvl_q;
			orate_q <= r_q;
			olast_q <= last_ch;
		end
	end

	assign out_valid   = ovalid_q;
	assign mode_flag   = omode_q;
	assign channel     = och_q;
	assign level_value = olvl_q;
	assign rate_value  = orate_q;
	assign last_of_run = olast_q;

endmodule
